/* rtl/core/gpm_pkg.sv */
`default_nettype none

package gpm_pkg;

	// Field widths of the channels and registers.
	localparam int SAMPLE_BITS = 16;
	localparam int MEAN_BITS   = 16;
	localparam int GAIN_BITS   = 16;
	localparam int DEGREE_BITS = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	// The exp table spans t = 0 .. 16 in 2**EXP_LOG2 steps.
	localparam int EXP_LOG2          = 8;
	localparam int EXP_TABLE_ENTRIES = 1 << EXP_LOG2;

	// Internal widths. t is kept as Q4.24, so 28 bits cover 0 .. 16.
	localparam int DIFF_BITS   = ((SAMPLE_BITS > MEAN_BITS) ? SAMPLE_BITS : MEAN_BITS) + 1;
	localparam int SQ_BITS     = 2 * DIFF_BITS;
	localparam int T_BITS      = 28;
	localparam int FRAC_BITS   = T_BITS - EXP_LOG2;
	localparam int FACTOR_BITS = 17;
	localparam int PROD_BITS   = 2 * FACTOR_BITS;

	localparam logic [FACTOR_BITS-1:0] FACTOR_ONE = FACTOR_BITS'(1) << 16;
	localparam logic [GAIN_BITS-1:0]   GAIN_RESET = GAIN_BITS'(128);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_MEAN_LEFT  = 2'd0,
		REG_GAIN_LEFT  = 2'd1,
		REG_MEAN_RIGHT = 2'd2,
		REG_GAIN_RIGHT = 2'd3
	} cfg_reg_t;

	// Load enables of the five stages inside a shoulder unit.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} shoulder_en_t;

	typedef logic [FACTOR_BITS-1:0] exp_rom_t [0:EXP_TABLE_ENTRIES];

	// Entry k is exp(-16*k/EXP_TABLE_ENTRIES) in Q1.16. The step ratio exp(-h) is a
	// truncated Taylor sum in Q.32 and the entries follow by repeated multiplication.
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t    rom;
		logic [63:0] h;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] e;
		int          i;
		h    = 64'd1 << (36 - EXP_LOG2);
		sum  = 64'd1 << 32;
		term = 64'd1 << 32;
		e    = 64'd1 << 32;
		for (i = 1; i <= 12; i++) begin
			term = ((term * h) >> 32) / 64'(i);
			if ((i % 2) == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		for (i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
			if (i > 0) begin
				e = (e * sum + (64'd1 << 31)) >> 32;
			end
			rom[i] = FACTOR_BITS'((e + (64'd1 << 15)) >> 16);
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

/* rtl/core/gpm_sample_if.sv */
`default_nettype none

interface gpm_sample_if import gpm_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          sample_invalid;

	modport source (output valid, sample, sample_invalid, input ready);
	modport sink (input valid, sample, sample_invalid, output ready);
endinterface

`default_nettype wire

/* rtl/core/gpm_degree_if.sv */
`default_nettype none

interface gpm_degree_if import gpm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [DEGREE_BITS-1:0] degree;
	logic                   degree_invalid;

	modport source (output valid, degree, degree_invalid, input ready);
	modport sink (input valid, degree, degree_invalid, output ready);
endinterface

`default_nettype wire

/* rtl/core/gaussian_product_membership_top.sv */
`default_nettype none

// Gaussian product membership: each signed Q8.8 sample gives a Q0.16 degree equal to
// the left shoulder exp(-(x-mean_left)^2*gain_left) for x at or below mean_left, times
// the right shoulder exp(-(x-mean_right)^2*gain_right) for x at or above mean_right,
// where each gain holds 1/(2*sigma^2). exp comes from a 257-entry table with linear
// interpolation; a full degree of one reads as 65535, and a sample marked invalid comes
// out as degree 0 marked invalid. The pipeline takes one sample per clock until
// backpressure from degree_ch fills it; the seven register stages are the distance,
// square, gain scaling, table read and interpolation of each shoulder, then the product
// of the two factors and the rounded, saturated degree. Stages hold their data under
// backpressure and empty stages fill up, so no request is lost or repeated. Registers
// are written through cfg_we/cfg_index/cfg_data and must only change while the pipeline
// is empty.
module gaussian_product_membership_top import gpm_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	gpm_sample_if.sink                     sample_ch,
	gpm_degree_if.source                   degree_ch
);

	logic signed [MEAN_BITS-1:0] mean_left_q;
	logic        [GAIN_BITS-1:0] gain_left_q;
	logic signed [MEAN_BITS-1:0] mean_right_q;
	logic        [GAIN_BITS-1:0] gain_right_q;

	logic signed [DIFF_BITS-1:0] x_w;
	logic signed [DIFF_BITS-1:0] ml_w;
	logic signed [DIFF_BITS-1:0] mr_w;
	logic                        act_left;
	logic                        act_right;

	logic en1, en2, en3, en4, en5, en6, en7;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic inv_s1, inv_s2, inv_s3, inv_s4, inv_s5, inv_s6, inv_s7;
	shoulder_en_t sh_en;

	logic [FACTOR_BITS-1:0] factor_left;
	logic [FACTOR_BITS-1:0] factor_right;
	logic [PROD_BITS-1:0]   prod_s6;
	logic [PROD_BITS-1:0]   prod_rnd;
	logic [DEGREE_BITS-1:0] degree_sat;
	logic [DEGREE_BITS-1:0] degree_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_left_q  <= '0;
			gain_left_q  <= GAIN_RESET;
			mean_right_q <= '0;
			gain_right_q <= GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MEAN_LEFT:  mean_left_q  <= MEAN_BITS'(cfg_data);
				REG_GAIN_LEFT:  gain_left_q  <= GAIN_BITS'(cfg_data);
				REG_MEAN_RIGHT: mean_right_q <= MEAN_BITS'(cfg_data);
				REG_GAIN_RIGHT: gain_right_q <= GAIN_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	// Each stage loads when it is empty or its contents move on in the same cycle.
	assign en7 = !v_s7 || degree_ch.ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign sample_ch.ready = en1;

	assign sh_en = '{s1: en1, s2: en2, s3: en3, s4: en4, s5: en5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= sample_ch.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	assign x_w       = DIFF_BITS'(sample_ch.sample);
	assign ml_w      = DIFF_BITS'(mean_left_q);
	assign mr_w      = DIFF_BITS'(mean_right_q);
	assign act_left  = (x_w <= ml_w);
	assign act_right = (x_w >= mr_w);

	gpm_shoulder u_left (
		.clk    (clk),
		.en     (sh_en),
		.x      (x_w),
		.mean   (ml_w),
		.gain   (gain_left_q),
		.active (act_left),
		.factor (factor_left)
	);

	gpm_shoulder u_right (
		.clk    (clk),
		.en     (sh_en),
		.x      (x_w),
		.mean   (mr_w),
		.gain   (gain_right_q),
		.active (act_right),
		.factor (factor_right)
	);

	assign prod_rnd   = prod_s6 + (PROD_BITS'(1) << 15);
	assign degree_sat = (prod_rnd[PROD_BITS-1:16+DEGREE_BITS] != '0) ?
		{DEGREE_BITS{1'b1}} : prod_rnd[16+DEGREE_BITS-1:16];

	always_ff @(posedge clk) begin
		if (en1) inv_s1 <= sample_ch.sample_invalid;
		if (en2) inv_s2 <= inv_s1;
		if (en3) inv_s3 <= inv_s2;
		if (en4) inv_s4 <= inv_s3;
		if (en5) inv_s5 <= inv_s4;
		if (en6) begin
			inv_s6  <= inv_s5;
			prod_s6 <= PROD_BITS'(factor_left) * PROD_BITS'(factor_right);
		end
		if (en7) begin
			inv_s7    <= inv_s6;
			degree_s7 <= inv_s6 ? '0 : degree_sat;
		end
	end

	assign degree_ch.valid          = v_s7;
	assign degree_ch.degree         = degree_s7;
	assign degree_ch.degree_invalid = inv_s7;

endmodule

`default_nettype wire

/* rtl/core/gpm_shoulder.sv */
`default_nettype none

// One Gaussian shoulder factor, exp(-(x-mean)^2 * gain) in Q1.16, over five stages:
// distance, square, scale by gain, table read, interpolation.
module gpm_shoulder import gpm_pkg::*; (
	input  wire logic                        clk,
	input  wire shoulder_en_t                en,
	input  wire logic signed [DIFF_BITS-1:0] x,
	input  wire logic signed [DIFF_BITS-1:0] mean,
	input  wire logic        [GAIN_BITS-1:0] gain,
	input  wire logic                        active,
	output logic             [FACTOR_BITS-1:0] factor
);

	localparam int TW = T_BITS + GAIN_BITS;
	localparam int IW = FACTOR_BITS + FRAC_BITS;
	localparam logic [IW-1:0] ROUND = IW'(1) << (FRAC_BITS - 1);

	logic signed [DIFF_BITS-1:0] diff;
	logic        [DIFF_BITS-1:0] abs_diff;
	logic        [TW-1:0]        t_full;
	logic                        sat;
	logic        [EXP_LOG2-1:0]  idx;
	logic        [EXP_LOG2:0]    idx_next;
	logic        [FACTOR_BITS-1:0] e0;
	logic        [FACTOR_BITS-1:0] e1;
	logic        [IW-1:0]        interp_full;
	logic        [FACTOR_BITS-1:0] interp;

	logic [DIFF_BITS-1:0]   ad_s1;
	logic                   act_s1;
	logic [SQ_BITS-1:0]     sq_s2;
	logic                   act_s2;
	logic [T_BITS-1:0]      t_s3;
	logic                   zero_s3;
	logic                   act_s3;
	logic [FACTOR_BITS-1:0] e0_s4;
	logic [FACTOR_BITS-1:0] slope_s4;
	logic [FRAC_BITS-1:0]   frac_s4;
	logic                   zero_s4;
	logic                   act_s4;
	logic [FACTOR_BITS-1:0] factor_s5;

	assign diff     = x - mean;
	assign abs_diff = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);

	// A zero gain keeps t at zero however far the sample lies.
	assign t_full = TW'(sq_s2[T_BITS-1:0]) * TW'(gain);
	assign sat    = (gain != '0) &&
		((sq_s2[SQ_BITS-1:T_BITS] != '0) || (t_full[TW-1:T_BITS] != '0));

	assign idx      = t_s3[T_BITS-1:FRAC_BITS];
	assign idx_next = {1'b0, idx} + (EXP_LOG2 + 1)'(1);
	assign e0       = EXP_ROM[idx];
	assign e1       = EXP_ROM[idx_next];

	assign interp_full = IW'(slope_s4) * IW'(frac_s4) + ROUND;
	assign interp      = interp_full[IW-1:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (en.s1) begin
			ad_s1  <= abs_diff;
			act_s1 <= active;
		end
		if (en.s2) begin
			sq_s2  <= SQ_BITS'(ad_s1) * SQ_BITS'(ad_s1);
			act_s2 <= act_s1;
		end
		if (en.s3) begin
			t_s3    <= t_full[T_BITS-1:0];
			zero_s3 <= sat;
			act_s3  <= act_s2;
		end
		if (en.s4) begin
			e0_s4    <= e0;
			slope_s4 <= e0 - e1;
			frac_s4  <= t_s3[FRAC_BITS-1:0];
			zero_s4  <= zero_s3;
			act_s4   <= act_s3;
		end
		if (en.s5) begin
			if (!act_s4) begin
				factor_s5 <= FACTOR_ONE;
			end else if (zero_s4) begin
				factor_s5 <= '0;
			end else begin
				factor_s5 <= e0_s4 - interp;
			end
		end
	end

	assign factor = factor_s5;

endmodule

`default_nettype wire

/* dv/testbench.sv */
`default_nettype none

module testbench;
	import gpm_pkg::*;

	localparam int PIPE_LATENCY   = 7;
	localparam int HOLD_CYCLES    = 400;
	localparam int STALL_LIMIT    = 4000;
	localparam int PHASES         = 6;
	localparam int PHASE_ITEMS    = 167;
	localparam int DIRECTED_ROWS  = 26;
	localparam int PRINT_LIMIT    = 50;
	localparam logic [63:0] T_LIMIT = 64'd1 << T_BITS;
	localparam logic [63:0] UNITY   = 64'd1 << 16;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_WRITE
	} row_kind_t;

	typedef enum logic [1:0] {
		PACE_SLOW_SINK,
		PACE_SLOW_SOURCE,
		PACE_FULL
	} pace_t;

	typedef struct packed {
		row_kind_t             kind;
		cfg_reg_t              target;
		logic [CFG_DATA_BITS-1:0] value;
		logic                  invalid;
		logic                  known;
		logic [DEGREE_BITS-1:0] known_degree;
	} stim_row_t;

	typedef struct packed {
		logic [DEGREE_BITS-1:0] degree;
		logic                   invalid;
	} degree_t;

	// Rows marked known carry a result that follows directly from the case;
	// the others are checked against the membership predictor.
	stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'h0000, 1'b0, 1'b1, 16'hFFFF},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'h0000, 1'b1, 1'b1, 16'h0000},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'h8000, 1'b0, 1'b1, 16'h0000},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'h7FFF, 1'b0, 1'b1, 16'h0000},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'hFFFF, 1'b1, 1'b1, 16'h0000},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'h0100, 1'b0, 1'b0, 16'h0000},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'hFF00, 1'b0, 1'b0, 16'h0000},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'h0001, 1'b0, 1'b0, 16'h0000},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'hFFFF, 1'b0, 1'b0, 16'h0000},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'h0400, 1'b0, 1'b0, 16'h0000},
		'{ROW_WRITE,  REG_GAIN_LEFT,  16'h0000, 1'b0, 1'b0, 16'h0000},
		'{ROW_WRITE,  REG_GAIN_RIGHT, 16'h0000, 1'b0, 1'b0, 16'h0000},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'h8000, 1'b0, 1'b1, 16'hFFFF},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'h7FFF, 1'b0, 1'b1, 16'hFFFF},
		'{ROW_WRITE,  REG_MEAN_LEFT,  16'h8000, 1'b0, 1'b0, 16'h0000},
		'{ROW_WRITE,  REG_MEAN_RIGHT, 16'h7FFF, 1'b0, 1'b0, 16'h0000},
		'{ROW_WRITE,  REG_GAIN_LEFT,  16'hFFFF, 1'b0, 1'b0, 16'h0000},
		'{ROW_WRITE,  REG_GAIN_RIGHT, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'h0000, 1'b0, 1'b1, 16'hFFFF},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'h8000, 1'b0, 1'b1, 16'hFFFF},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'h7FFF, 1'b0, 1'b1, 16'hFFFF},
		'{ROW_WRITE,  REG_MEAN_LEFT,  16'h0000, 1'b0, 1'b0, 16'h0000},
		'{ROW_WRITE,  REG_MEAN_RIGHT, 16'h0000, 1'b0, 1'b0, 16'h0000},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'h0001, 1'b0, 1'b0, 16'h0000},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'h0010, 1'b0, 1'b0, 16'h0000},
		'{ROW_SAMPLE, REG_MEAN_LEFT,  16'h0000, 1'b0, 1'b1, 16'hFFFF}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	gpm_sample_if sample_bus ();
	gpm_degree_if degree_bus ();

	gaussian_product_membership_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_ch (sample_bus),
		.degree_ch (degree_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic signed [MEAN_BITS-1:0] cfg_mean_left  = '0;
	logic signed [MEAN_BITS-1:0] cfg_mean_right = '0;
	logic [GAIN_BITS-1:0]        cfg_gain_left  = GAIN_RESET;
	logic [GAIN_BITS-1:0]        cfg_gain_right = GAIN_RESET;

	logic [FACTOR_BITS-1:0] decay_table [0:EXP_TABLE_ENTRIES];

	degree_t expected_degrees [$];
	degree_t want_degree;
	int      mismatch_count = 0;
	int      quiet_cycles   = 0;
	pace_t   pace           = PACE_SLOW_SINK;
	int      hold_requests  = 0;
	int      hold_served    = 0;
	int      hold_left      = 0;

	// Set by the sender together with each request, read when it is taken.
	logic                   pin_known  = 1'b0;
	logic [DEGREE_BITS-1:0] pin_degree = '0;

	function automatic logic [FACTOR_BITS-1:0] shoulder_factor(
		input logic signed [SAMPLE_BITS-1:0] x,
		input logic signed [MEAN_BITS-1:0]   center,
		input logic [GAIN_BITS-1:0]          gain
	);
		logic signed [DIFF_BITS:0] offset_x;
		logic [63:0] mag;
		logic [63:0] sq;
		logic [63:0] t;
		logic [63:0] p;
		logic [63:0] idx;
		logic [63:0] frac;
		logic [63:0] e0;
		logic [63:0] e1;
		offset_x = x - center;
		mag  = (offset_x < 0) ? 64'(-offset_x) : 64'(offset_x);
		sq   = mag * mag;
		if (gain == '0) begin
			t = '0;
		end else if (sq >= T_LIMIT) begin
			t = T_LIMIT;
		end else begin
			t = sq * 64'(gain);
		end
		if (t >= T_LIMIT) begin
			return '0;
		end
		p    = t * 64'(EXP_TABLE_ENTRIES);
		idx  = p >> T_BITS;
		frac = p & (T_LIMIT - 64'd1);
		if (idx >= 64'(EXP_TABLE_ENTRIES)) begin
			return '0;
		end
		e0 = 64'(decay_table[idx]);
		e1 = 64'(decay_table[idx + 1]);
		return FACTOR_BITS'(e0 - (((e0 - e1) * frac + (64'd1 << 27)) >> T_BITS));
	endfunction

	function automatic degree_t predict_degree(
		input logic signed [SAMPLE_BITS-1:0] x,
		input logic                          invalid
	);
		logic [63:0] left_f;
		logic [63:0] right_f;
		logic [63:0] prod;
		if (invalid) begin
			return '{degree: '0, invalid: 1'b1};
		end
		left_f  = UNITY;
		right_f = UNITY;
		if (x <= cfg_mean_left) begin
			left_f = 64'(shoulder_factor(x, cfg_mean_left, cfg_gain_left));
		end
		if (x >= cfg_mean_right) begin
			right_f = 64'(shoulder_factor(x, cfg_mean_right, cfg_gain_right));
		end
		prod = (left_f * right_f + (64'd1 << 15)) >> 16;
		if (prod > 64'd65535) begin
			prod = 64'd65535;
		end
		return '{degree: DEGREE_BITS'(prod), invalid: 1'b0};
	endfunction

	// Half the samples land near a shoulder mean, so the table is swept end to end.
	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		logic signed [SAMPLE_BITS-1:0] base;
		logic [SAMPLE_BITS-1:0]        offset;
		case ($urandom_range(0, 3))
			0: begin
				return SAMPLE_BITS'($urandom);
			end
			1: begin
				base = cfg_mean_left;
			end
			2: begin
				base = cfg_mean_right;
			end
			default: begin
				base = (cfg_mean_left >>> 1) + (cfg_mean_right >>> 1);
			end
		endcase
		offset = SAMPLE_BITS'($urandom) >> $urandom_range(0, 15);
		return ($urandom_range(0, 1) == 1) ? base + offset : base - offset;
	endfunction

	function automatic logic idles(input logic sink);
		int unsigned pct;
		case (pace)
			PACE_SLOW_SINK: begin
				pct = sink ? 85 : 37;
			end
			PACE_SLOW_SOURCE: begin
				pct = sink ? 37 : 85;
			end
			default: begin
				pct = 0;
			end
		endcase
		return $urandom_range(0, 99) < pct;
	endfunction

	task automatic report_error(input string msg);
		if (mismatch_count < PRINT_LIMIT) begin
			$display("ERROR: %s", msg);
		end
		mismatch_count++;
	endtask

	task automatic send_sample(
		input logic [SAMPLE_BITS-1:0] value,
		input logic                   invalid,
		input logic                   known,
		input logic [DEGREE_BITS-1:0] known_degree
	);
		while (idles(1'b0)) begin
			sample_bus.valid <= 1'b0;
			@(posedge clk);
		end
		pin_known  = known;
		pin_degree = known_degree;
		sample_bus.valid          <= 1'b1;
		sample_bus.sample         <= value;
		sample_bus.sample_invalid <= invalid;
		@(negedge clk);
		while (!sample_bus.ready) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	// Registers may only change with the pipeline empty.
	task automatic settle_pipeline();
		sample_bus.valid <= 1'b0;
		@(posedge clk);
		while (expected_degrees.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_LATENCY + 3) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t target, input logic [CFG_DATA_BITS-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= target;
		cfg_data  <= value;
		case (target)
			REG_MEAN_LEFT: begin
				cfg_mean_left = value;
			end
			REG_GAIN_LEFT: begin
				cfg_gain_left = value;
			end
			REG_MEAN_RIGHT: begin
				cfg_mean_right = value;
			end
			default: begin
				cfg_gain_right = value;
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(
		input logic [CFG_DATA_BITS-1:0] mean_l,
		input logic [CFG_DATA_BITS-1:0] gain_l,
		input logic [CFG_DATA_BITS-1:0] mean_r,
		input logic [CFG_DATA_BITS-1:0] gain_r
	);
		settle_pipeline();
		write_register(REG_MEAN_LEFT, mean_l);
		write_register(REG_GAIN_LEFT, gain_l);
		write_register(REG_MEAN_RIGHT, mean_r);
		write_register(REG_GAIN_RIGHT, gain_r);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			degree_bus.ready <= 1'b0;
		end else if (hold_left > 0) begin
			degree_bus.ready <= 1'b0;
			hold_left        <= hold_left - 1;
		end else if (hold_requests != hold_served) begin
			degree_bus.ready <= 1'b0;
			hold_left        <= HOLD_CYCLES;
			hold_served      <= hold_served + 1;
		end else begin
			degree_bus.ready <= !idles(1'b1);
		end
	end

	always @(negedge clk) begin
		if (arst_n && sample_bus.valid && sample_bus.ready) begin
			if (pin_known) begin
				expected_degrees.push_back('{degree: pin_degree,
					invalid: sample_bus.sample_invalid});
			end else begin
				expected_degrees.push_back(predict_degree(sample_bus.sample,
					sample_bus.sample_invalid));
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && degree_bus.valid && degree_bus.ready) begin
			if (expected_degrees.size() == 0) begin
				report_error($sformatf("degree %0d arrived with no request pending",
					degree_bus.degree));
			end else begin
				want_degree = expected_degrees.pop_front();
				if (degree_bus.degree !== want_degree.degree) begin
					report_error($sformatf("degree got %0d expected %0d",
						degree_bus.degree, want_degree.degree));
				end
				if (degree_bus.degree_invalid !== want_degree.invalid) begin
					report_error($sformatf("degree_invalid got %0b expected %0b",
						degree_bus.degree_invalid, want_degree.invalid));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((sample_bus.valid && sample_bus.ready) || (degree_bus.valid && degree_bus.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("testbench failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		logic [63:0] step;
		logic [63:0] ratio;
		logic [63:0] term;
		logic [63:0] acc;
		logic [CFG_DATA_BITS-1:0] base_mean;
		int k;
		int ph;
		int n;
		int issued;

		// exp(-16/N) as a Taylor sum, then the table by repeated multiplication.
		step  = (64'd1 << 36) / 64'(EXP_TABLE_ENTRIES);
		ratio = 64'd1 << 32;
		term  = 64'd1 << 32;
		acc   = 64'd1 << 32;
		for (k = 1; k <= 12; k++) begin
			term = ((term * step) >> 32) / 64'(k);
			if ((k % 2) == 1) begin
				ratio = ratio - term;
			end else begin
				ratio = ratio + term;
			end
		end
		for (k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
			if (k > 0) begin
				acc = (acc * ratio + (64'd1 << 31)) >> 32;
			end
			decay_table[k] = FACTOR_BITS'((acc + (64'd1 << 15)) >> 16);
		end

		arst_n                    = 1'b0;
		cfg_we                    = 1'b0;
		cfg_index                 = '0;
		cfg_data                  = '0;
		sample_bus.valid          = 1'b0;
		sample_bus.sample         = '0;
		sample_bus.sample_invalid = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < DIRECTED_ROWS; k++) begin
			if (directed_rows[k].kind == ROW_WRITE) begin
				settle_pipeline();
				write_register(directed_rows[k].target, directed_rows[k].value);
			end else begin
				send_sample(directed_rows[k].value, directed_rows[k].invalid,
					directed_rows[k].known, directed_rows[k].known_degree);
			end
		end

		issued = 0;
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					load_settings(16'hFF00, 16'h0100, 16'h0100, 16'h0100);
				end
				1: begin
					load_settings(16'h8000, 16'hFFFF, 16'h7FFF, 16'h0000);
				end
				2: begin
					load_settings(16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF);
				end
				default: begin
					base_mean = CFG_DATA_BITS'($urandom);
					load_settings(base_mean, GAIN_BITS'($urandom) >> $urandom_range(0, 15),
						base_mean + CFG_DATA_BITS'($urandom_range(0, 4096)),
						GAIN_BITS'($urandom) >> $urandom_range(0, 15));
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (issued == (PHASES * PHASE_ITEMS) / 3) begin
					pace = PACE_SLOW_SOURCE;
				end else if (issued == (2 * PHASES * PHASE_ITEMS) / 3) begin
					// Stop draining results for a while so the pipeline backs up.
					pace = PACE_FULL;
					hold_requests++;
				end
				send_sample(random_sample(), $urandom_range(0, 9) == 0, 1'b0, '0);
				issued++;
			end
		end

		settle_pipeline();
		if (mismatch_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
